// ----- src/spirv_header_scanner_unit_macros.svh -----
// Assertion macros for the header scanner checkers.
`ifndef SPIRV_HEADER_SCANNER_UNIT_MACROS_SVH
`define SPIRV_HEADER_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("header scanner check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("header scanner check failed");

`endif

// ----- src/spirv_hs_pkg.sv -----
package spirv_hs_pkg;

	localparam int unsigned HEADER_WORDS_DEF = 5;
	localparam logic [31:0] SPV_MAGIC        = 32'h0723_0203;

	localparam logic [15:0] OP_ENTRY_POINT = 16'd15;
	localparam logic [15:0] OP_CAPABILITY  = 16'd17;
	localparam logic [15:0] OP_FUNCTION    = 16'd54;

	// record kinds
	localparam logic [2:0] K_CAP      = 3'd0;
	localparam logic [2:0] K_MODEL    = 3'd1;
	localparam logic [2:0] K_BYTE     = 3'd2;
	localparam logic [2:0] K_NAME_END = 3'd3;
	localparam logic [2:0] K_OK       = 3'd4;
	localparam logic [2:0] K_FAIL     = 3'd5;

	// fail codes
	localparam logic [31:0] E_SHORT   = 32'd0;
	localparam logic [31:0] E_MAGIC   = 32'd1;
	localparam logic [31:0] E_ZERO    = 32'd2;
	localparam logic [31:0] E_OVERRUN = 32'd3;

	// most records one word can produce: four name bytes, name end, ok
	localparam int unsigned MAX_RECS = 6;
	localparam int unsigned REC_IDX_W = $clog2(MAX_RECS);
	localparam int unsigned REC_CNT_W = $clog2(MAX_RECS + 1);

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_START  = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  header_pos;
		logic        magic_bad;
		logic [15:0] words_left;
		logic [15:0] operand_pos;
		logic [15:0] cur_opcode;
		logic        name_open;
		logic        stop_after_inst;
	} state_t;

	localparam state_t ST_RESET = '{
		phase:           PH_HEADER,
		header_pos:      3'd0,
		magic_bad:       1'b0,
		words_left:      16'd0,
		operand_pos:     16'd0,
		cur_opcode:      16'd0,
		name_open:       1'b0,
		stop_after_inst: 1'b0
	};

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
	} rec_t;

	typedef struct packed {
		rec_t [MAX_RECS-1:0]  recs;
		logic [REC_CNT_W-1:0] cnt;
	} bundle_t;

endpackage

// ----- src/spirv_hs_if.sv -----
// Module word channel.
interface spirv_hs_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        final_word;

	modport source (output valid, word, final_word, input ready);
	modport sink   (input valid, word, final_word, output ready);
endinterface

// Record channel.
interface spirv_hs_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  rec_kind;
	logic [31:0] rec_value;
	logic        run_last;

	modport source (output valid, rec_kind, rec_value, run_last, input ready);
	modport sink   (input valid, rec_kind, rec_value, run_last, output ready);
endinterface

// ----- src/spirv_header_scanner_unit.sv -----
// Channel | Dir | Payload                          | Accept
// words   | in  | word[31:0], final_word           | valid & ready
// recs    | out | rec_kind[2:0], rec_value[31:0],  | valid & ready
//         |     | run_last                         |
//
// One module word is accepted per cycle while the record buffer keeps up.
// A word waits in the input register, then its records (0..6) leave the
// record buffer one per cycle while recs is ready; a word with k > 1 records
// holds the input side until its last record leaves. The single output port
// of the record buffer sets that limit.
// arst_n clears the parser state and empties both stages.
// A stall on recs backs up into words only once the input register is full.
module spirv_header_scanner_unit #(
	parameter int unsigned HEADER_WORDS = spirv_hs_pkg::HEADER_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	spirv_hs_word_if.sink  words,
	spirv_hs_rec_if.source recs
);

	// input register
	logic                  valid_s1;
	logic [31:0]           word_s1;
	logic                  final_s1;

	// word in s1 is decoded and handed to the record buffer this cycle
	logic                  fire;
	logic                  free;
	spirv_hs_pkg::bundle_t bundle;

	assign fire        = valid_s1 && free;
	assign words.ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1  <= words.word;
			final_s1 <= words.final_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.valid && words.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// header check, instruction walk, record decode; state advances on fire
	spirv_hs_step #(
		.HEADER_WORDS (HEADER_WORDS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.word       (word_s1),
		.final_word (final_s1),
		.bundle     (bundle)
	);

	// the bundle is loaded as the previous one's last record leaves, or while the buffer is empty
	spirv_hs_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.bundle (bundle),
		.free   (free),
		.recs   (recs)
	);

endmodule

// ----- src/spirv_hs_step.sv -----
// Parser state and the per-word decode into a bundle of records.
module spirv_hs_step #(
	parameter int unsigned HEADER_WORDS = spirv_hs_pkg::HEADER_WORDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [31:0]           word,
	input  logic                  final_word,
	output spirv_hs_pkg::bundle_t bundle
);

	localparam logic [3:0] HDR_LEN = 4'(HEADER_WORDS);

	spirv_hs_pkg::state_t st_q;
	spirv_hs_pkg::state_t st_nx;

	always_comb begin
		logic [3:0]                           hp_inc;
		logic                                 mb;
		logic [15:0]                          wc;
		logic [15:0]                          op;
		logic [15:0]                          wl_dec;
		logic [7:0]                           c;
		logic                                 open_v;
		logic [spirv_hs_pkg::REC_CNT_W-1:0]   n;

		st_nx  = st_q;
		bundle = '0;
		n      = '0;
		hp_inc = {1'b0, st_q.header_pos} + 4'd1;
		mb     = st_q.magic_bad |
			((st_q.header_pos == 3'd0) && (word != spirv_hs_pkg::SPV_MAGIC));
		wc     = word[31:16];
		op     = word[15:0];
		wl_dec = st_q.words_left - 16'd1;
		c      = '0;
		open_v = st_q.name_open;

		case (st_q.phase)
			spirv_hs_pkg::PH_HEADER: begin
				st_nx.magic_bad = mb;
				if (hp_inc >= HDR_LEN) begin
					if (mb) begin
						bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
							'{spirv_hs_pkg::K_FAIL, spirv_hs_pkg::E_MAGIC};
						n = n + 1'b1;
						st_nx.phase = spirv_hs_pkg::PH_DONE;
					end else if (final_word) begin
						bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
							'{spirv_hs_pkg::K_OK, 32'd0};
						n = n + 1'b1;
						st_nx.phase = spirv_hs_pkg::PH_DONE;
					end else begin
						st_nx.phase = spirv_hs_pkg::PH_START;
					end
				end else if (final_word) begin
					bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
						'{spirv_hs_pkg::K_FAIL, spirv_hs_pkg::E_SHORT};
					n = n + 1'b1;
					st_nx.phase = spirv_hs_pkg::PH_DONE;
				end else begin
					st_nx.header_pos = hp_inc[2:0];
				end
			end
			spirv_hs_pkg::PH_START: begin
				if (wc == 16'd0) begin
					bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
						'{spirv_hs_pkg::K_FAIL, spirv_hs_pkg::E_ZERO};
					n = n + 1'b1;
					st_nx.phase = spirv_hs_pkg::PH_DONE;
				end else if (wc == 16'd1) begin
					if ((op == spirv_hs_pkg::OP_FUNCTION) || final_word) begin
						bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
							'{spirv_hs_pkg::K_OK, 32'd0};
						n = n + 1'b1;
						st_nx.phase = spirv_hs_pkg::PH_DONE;
					end
				end else if (final_word) begin
					bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
						'{spirv_hs_pkg::K_FAIL, spirv_hs_pkg::E_OVERRUN};
					n = n + 1'b1;
					st_nx.phase = spirv_hs_pkg::PH_DONE;
				end else begin
					st_nx.words_left      = wc - 16'd1;
					st_nx.operand_pos     = '0;
					st_nx.cur_opcode      = op;
					st_nx.name_open       = 1'b0;
					st_nx.stop_after_inst = (op == spirv_hs_pkg::OP_FUNCTION);
					st_nx.phase           = spirv_hs_pkg::PH_BODY;
				end
			end
			spirv_hs_pkg::PH_BODY: begin
				if ((st_q.cur_opcode == spirv_hs_pkg::OP_CAPABILITY) &&
					(st_q.operand_pos == 16'd0)) begin
					bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
						'{spirv_hs_pkg::K_CAP, word};
					n = n + 1'b1;
				end else if (st_q.cur_opcode == spirv_hs_pkg::OP_ENTRY_POINT) begin
					if ((st_q.operand_pos == 16'd0) && (st_q.words_left >= 16'd3)) begin
						bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
							'{spirv_hs_pkg::K_MODEL, word};
						n = n + 1'b1;
						open_v = 1'b1;
					end else if ((st_q.operand_pos >= 16'd2) && open_v) begin
						// name bytes, low byte first, stop at NUL
						for (int i = 0; i < 4; i++) begin
							if (open_v) begin
								c = word[8*i +: 8];
								if (c == 8'd0) begin
									bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
										'{spirv_hs_pkg::K_NAME_END, 32'd0};
									open_v = 1'b0;
								end else begin
									bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
										'{spirv_hs_pkg::K_BYTE, {24'd0, c}};
								end
								n = n + 1'b1;
							end
						end
					end
				end
				st_nx.words_left  = wl_dec;
				st_nx.operand_pos = st_q.operand_pos + 16'd1;
				if (wl_dec == 16'd0) begin
					if (open_v) begin
						bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
							'{spirv_hs_pkg::K_NAME_END, 32'd0};
						n = n + 1'b1;
						open_v = 1'b0;
					end
					if (st_q.stop_after_inst || final_word) begin
						bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
							'{spirv_hs_pkg::K_OK, 32'd0};
						n = n + 1'b1;
						st_nx.phase = spirv_hs_pkg::PH_DONE;
					end else begin
						st_nx.phase = spirv_hs_pkg::PH_START;
					end
				end else if (final_word) begin
					bundle.recs[n[spirv_hs_pkg::REC_IDX_W-1:0]] =
						'{spirv_hs_pkg::K_FAIL, spirv_hs_pkg::E_OVERRUN};
					n = n + 1'b1;
					st_nx.phase = spirv_hs_pkg::PH_DONE;
				end
				st_nx.name_open = open_v;
			end
			default: begin
				// done: words ignored until the final one
			end
		endcase

		if (final_word) begin
			st_nx = spirv_hs_pkg::ST_RESET;
		end
		bundle.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= spirv_hs_pkg::ST_RESET;
		end else if (fire) begin
			st_q <= st_nx;
		end
	end

endmodule

// ----- src/spirv_hs_emit.sv -----
// Record buffer: holds one word's bundle, plays it out one record per ready cycle.
module spirv_hs_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  spirv_hs_pkg::bundle_t bundle,
	output logic                  free,
	spirv_hs_rec_if.source        recs
);

	spirv_hs_pkg::rec_t [spirv_hs_pkg::MAX_RECS-1:0] recs_q;
	logic [spirv_hs_pkg::REC_CNT_W-1:0]               cnt_q;
	logic [spirv_hs_pkg::REC_IDX_W-1:0]               rd_q;
	logic [spirv_hs_pkg::REC_IDX_W-1:0]               last_idx;
	logic                                             last;
	logic                                             take;

	assign last_idx = cnt_q[spirv_hs_pkg::REC_IDX_W-1:0] - 1'b1;
	assign last = (rd_q == last_idx);
	assign take = recs.valid && recs.ready;
	assign free = !recs.valid || (take && last);

	assign recs.valid     = (cnt_q != '0);
	assign recs.rec_kind  = recs_q[rd_q].kind;
	assign recs.rec_value = recs_q[rd_q].value;
	assign recs.run_last  = last;

	always_ff @(posedge clk) begin
		if (load) begin
			recs_q <= bundle.recs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
			rd_q  <= '0;
		end else if (take) begin
			if (last) begin
				cnt_q <= '0;
				rd_q  <= '0;
			end else begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

endmodule

// ----- src/spirv_hs_checker.sv -----
`include "spirv_header_scanner_unit_macros.svh"

module spirv_hs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  rec_kind,
	input logic [31:0] rec_value,
	input logic        run_last
);

	`SHS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rec_kind) && $stable(rec_value) && $stable(run_last))

	`SHS_ASSERT_IMP(a_bp_from_out, clk, arst_n, in_valid && !in_ready, out_valid)

	`SHS_ASSERT_NXT(a_run_cont, clk, arst_n, out_valid && out_ready && !run_last, out_valid)

	`SHS_ASSERT_IMP(a_end_is_last, clk, arst_n, out_valid && (rec_kind == spirv_hs_pkg::K_OK || rec_kind == spirv_hs_pkg::K_FAIL), run_last)

endmodule

bind spirv_header_scanner_unit spirv_hs_checker u_spirv_hs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (words.valid),
	.in_ready  (words.ready),
	.out_valid (recs.valid),
	.out_ready (recs.ready),
	.rec_kind  (recs.rec_kind),
	.rec_value (recs.rec_value),
	.run_last  (recs.run_last)
);

// ----- tb/spirv_hs_scan_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, runs its own model of the scanner on every accepted
// module word and compares each record against the oldest one still owed.
module spirv_hs_scan_checker #(
	parameter int unsigned HDR_WORDS = spirv_hs_pkg::HEADER_WORDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spirv_hs_word_if  words,
	spirv_hs_rec_if   recs,
	output int        errors,
	output int        pending,
	output int        recs_checked
);
	import spirv_hs_pkg::*;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] value;
		logic        last;
	} rec_exp_t;

	rec_exp_t owed_recs[$];   // records still due from the block
	rec_exp_t word_recs[$];   // records of the word being scanned
	rec_exp_t head;
	state_t   scan;

	task automatic report(input string msg);
		$display("%0t ns  record check: %s", $time, msg);
		errors++;
	endtask

	function automatic void add_rec(input logic [2:0] kind, input logic [31:0] value);
		rec_exp_t r;
		r.kind  = kind;
		r.value = value;
		r.last  = 1'b0;
		if (word_recs.size() < MAX_RECS)
			word_recs.insert(word_recs.size(), r);
	endfunction

	function automatic void close_scan(input logic [2:0] kind, input logic [31:0] value);
		add_rec(kind, value);
		scan.phase = PH_DONE;
	endfunction

	// one module word through the scanner state
	function automatic void scan_word(input logic [31:0] w, input logic fin);
		logic [15:0] wc;
		logic [15:0] op;
		logic [7:0]  c;
		word_recs.delete();
		wc = w[31:16];
		op = w[15:0];
		case (scan.phase)
			PH_HEADER: begin
				if (scan.header_pos == 3'd0 && w != SPV_MAGIC)
					scan.magic_bad = 1'b1;
				if (int'(scan.header_pos) + 1 >= int'(HDR_WORDS)) begin
					if (scan.magic_bad)
						close_scan(K_FAIL, E_MAGIC);
					else if (fin)
						close_scan(K_OK, 32'd0);
					else
						scan.phase = PH_START;
				end else if (fin) begin
					close_scan(K_FAIL, E_SHORT);
				end else begin
					scan.header_pos = scan.header_pos + 3'd1;
				end
			end
			PH_START: begin
				if (wc == 16'd0) begin
					close_scan(K_FAIL, E_ZERO);
				end else if (wc == 16'd1) begin
					if (op == OP_FUNCTION || fin)
						close_scan(K_OK, 32'd0);
				end else if (fin) begin
					close_scan(K_FAIL, E_OVERRUN);
				end else begin
					scan.words_left      = wc - 16'd1;
					scan.operand_pos     = 16'd0;
					scan.cur_opcode      = op;
					scan.name_open       = 1'b0;
					scan.stop_after_inst = (op == OP_FUNCTION);
					scan.phase           = PH_BODY;
				end
			end
			PH_BODY: begin
				if (scan.cur_opcode == OP_CAPABILITY && scan.operand_pos == 16'd0) begin
					add_rec(K_CAP, w);
				end else if (scan.cur_opcode == OP_ENTRY_POINT) begin
					if (scan.operand_pos == 16'd0 && scan.words_left >= 16'd3) begin
						add_rec(K_MODEL, w);
						scan.name_open = 1'b1;
					end else if (scan.operand_pos >= 16'd2 && scan.name_open) begin
						for (int b = 0; b < 4 && scan.name_open; b++) begin
							c = w[8*b +: 8];
							if (c == 8'd0) begin
								add_rec(K_NAME_END, 32'd0);
								scan.name_open = 1'b0;
							end else begin
								add_rec(K_BYTE, {24'd0, c});
							end
						end
					end
				end
				scan.words_left  = scan.words_left - 16'd1;
				scan.operand_pos = scan.operand_pos + 16'd1;
				if (scan.words_left == 16'd0) begin
					if (scan.name_open) begin
						add_rec(K_NAME_END, 32'd0);
						scan.name_open = 1'b0;
					end
					if (scan.stop_after_inst || fin)
						close_scan(K_OK, 32'd0);
					else
						scan.phase = PH_START;
				end else if (fin) begin
					close_scan(K_FAIL, E_OVERRUN);
				end
			end
			default: ;
		endcase
		if (fin)
			scan = ST_RESET;
		if (word_recs.size() > 0)
			word_recs[word_recs.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan = ST_RESET;
			owed_recs.delete();
			errors = 0;
			recs_checked = 0;
			pending <= 0;
		end else begin
			// records first: a word accepted at this edge cannot have produced one yet
			if (recs.valid && recs.ready) begin
				recs_checked++;
				if (owed_recs.size() == 0) begin
					report($sformatf("unexpected record kind %0d value 0x%08h",
						recs.rec_kind, recs.rec_value));
				end else begin
					head = owed_recs.pop_front();
					if (recs.rec_kind !== head.kind)
						report($sformatf("rec_kind %0d, want %0d", recs.rec_kind, head.kind));
					if (recs.rec_value !== head.value)
						report($sformatf("rec_value 0x%08h, want 0x%08h",
							recs.rec_value, head.value));
					if (recs.run_last !== head.last)
						report($sformatf("run_last %0b, want %0b", recs.run_last, head.last));
				end
			end
			if (words.valid && words.ready) begin
				scan_word(words.word, words.final_word);
				foreach (word_recs[i])
					owed_recs.insert(owed_recs.size(), word_recs[i]);
			end
			pending <= owed_recs.size();
		end
	end

endmodule

// ----- tb/tb_spirv_header_scanner_unit.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the SPIR-V header scanner. Modules are built as
// word lists (header, instructions, some ending) and streamed in; the checker
// beside the block predicts and compares every record.
module tb_spirv_header_scanner_unit;
	import spirv_hs_pkg::*;

	localparam int unsigned HDR = HEADER_WORDS_DEF;
	localparam int WORD_TARGET  = 470;

	typedef struct {
		logic [31:0] w;
		logic        fin;
	} mod_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spirv_hs_word_if words_ch();
	spirv_hs_rec_if  recs_ch();

	int errors;
	int pending;
	int recs_checked;

	int        words_sent = 0;
	int        modules_sent = 0;
	logic      calm;
	mod_word_t mod_q[$];

	spirv_header_scanner_unit #(.HEADER_WORDS(HDR)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words_ch),
		.recs   (recs_ch)
	);

	spirv_hs_scan_checker #(.HDR_WORDS(HDR)) scan_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.words        (words_ch),
		.recs         (recs_ch),
		.errors       (errors),
		.pending      (pending),
		.recs_checked (recs_checked)
	);

	always #5 clk = ~clk;

	// Quiet stretch in the middle of the run: no gaps on either side, so the
	// record buffer sees back-to-back multi-record words at full rate.
	assign calm = (words_sent >= 200) && (words_sent < 320);

	// record side: ready low about 35 percent of the time outside the quiet stretch
	always @(posedge clk)
		recs_ch.ready <= calm || ($urandom_range(0, 99) >= 35);

	// Hard stop, far beyond the slowest legal run (~600 words x 6 records with stalls).
	initial begin
		#5_000_000;
		$display("spirv_header_scanner_unit: mismatch");
		$finish;
	end

	task automatic add_word(input logic [31:0] w);
		mod_word_t mw;
		mw.w   = w;
		mw.fin = 1'b0;
		mod_q.insert(mod_q.size(), mw);
	endtask

	// Stream the queued module; its last word always carries final_word.
	task automatic send_module();
		mod_q[mod_q.size() - 1].fin = 1'b1;
		foreach (mod_q[i]) begin
			// random gaps on the word side
			while (!calm && $urandom_range(0, 99) < 35) begin
				words_ch.valid <= 1'b0;
				@(posedge clk);
			end
			words_ch.valid      <= 1'b1;
			words_ch.word       <= mod_q[i].w;
			words_ch.final_word <= mod_q[i].fin;
			@(posedge clk);
			while (!words_ch.ready)
				@(posedge clk);
			words_sent++;
		end
		mod_q.delete();
		modules_sent++;
	endtask

	task automatic add_header(input logic good_magic);
		add_word(good_magic ? SPV_MAGIC : $urandom);
		for (int i = 1; i < int'(HDR); i++)
			add_word($urandom);
	endtask

	// One random instruction that is not OpFunction.
	task automatic add_inst();
		logic [15:0] wc;
		logic [15:0] op;
		logic [31:0] nw;
		int          len;
		int          pos;
		case ($urandom_range(0, 2))
			0: begin
				wc = 16'($urandom_range(2, 4));
				add_word({wc, OP_CAPABILITY});
				add_word($urandom_range(0, 1) ? 32'($urandom_range(0, 70)) : $urandom);
				for (int i = 2; i < int'(wc); i++)
					add_word($urandom);
			end
			1: begin
				// word counts 2 and 3 are the short entry point, nothing emitted
				wc = 16'($urandom_range(2, 9));
				add_word({wc, OP_ENTRY_POINT});
				add_word($urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : $urandom);
				if (wc >= 16'd3)
					add_word($urandom);
				len = (wc > 16'd3) ? $urandom_range(0, 4 * (int'(wc) - 3) + 1) : 0;
				for (int j = 0; j < int'(wc) - 3; j++) begin
					for (int b = 0; b < 4; b++) begin
						pos = 4 * j + b;
						if (pos < len)
							nw[8*b +: 8] = 8'($urandom_range(1, 255));
						else if (pos == len)
							nw[8*b +: 8] = 8'd0;
						else
							nw[8*b +: 8] = 8'($urandom_range(0, 255));
					end
					add_word(nw);
				end
			end
			default: begin
				op = 16'($urandom);
				if (op == OP_CAPABILITY || op == OP_ENTRY_POINT || op == OP_FUNCTION)
					op = 16'd0;
				wc = 16'($urandom_range(1, 5));
				add_word({wc, op});
				for (int i = 1; i < int'(wc); i++)
					add_word($urandom);
			end
		endcase
	endtask

	task automatic add_junk(input int max_n);
		int n;
		n = $urandom_range(0, max_n);
		repeat (n) add_word($urandom);
	endtask

	task automatic build_random_module();
		int          r;
		int          n;
		int          ops;
		logic [15:0] wc;
		logic [15:0] op;
		r = $urandom_range(0, 99);
		if (r < 5 && HDR > 1) begin
			// module ends inside the header
			n = $urandom_range(1, HDR - 1);
			add_word($urandom_range(0, 1) ? SPV_MAGIC : $urandom);
			for (int i = 1; i < n; i++)
				add_word($urandom);
			return;
		end
		if (r < 10) begin
			// plain noise
			n = $urandom_range(1, 10);
			repeat (n) add_word($urandom);
			return;
		end
		add_header(r >= 14);
		r = $urandom_range(0, 99);
		if (r < 8)
			return;  // header only: ok, or a magic fail, on its last word
		n = $urandom_range(0, 6);
		repeat (n) add_inst();
		if (r < 40) begin
			// OpFunction closes the scan; anything after it is ignored
			wc = 16'($urandom_range(1, 4));
			add_word({wc, OP_FUNCTION});
			for (int i = 1; i < int'(wc); i++)
				add_word($urandom);
			add_junk(2);
		end else if (r < 65) begin
			// module ends on an instruction boundary
			if (mod_q.size() == HDR)
				add_inst();
		end else if (r < 85) begin
			// final word arrives before the instruction is complete
			wc = $urandom_range(0, 3) ? 16'($urandom_range(2, 12))
				: 16'($urandom_range(2, 65535));
			case ($urandom_range(0, 3))
				0: op = OP_CAPABILITY;
				1: op = OP_ENTRY_POINT;
				2: op = OP_FUNCTION;
				default: op = 16'($urandom);
			endcase
			add_word({wc, op});
			ops = $urandom_range(0, (int'(wc) - 2 < 6) ? int'(wc) - 2 : 6);
			repeat (ops) add_word($urandom);
		end else begin
			// zero word count
			add_word({16'd0, 16'($urandom)});
			add_junk(2);
		end
	endtask

	initial begin
		words_ch.valid      = 1'b0;
		words_ch.word       = 32'd0;
		words_ch.final_word = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad magic in a module cut short -> too-short wins
		add_word(32'hFFFF_FFFF);
		add_word(32'h0000_0000);
		send_module();

		// Directed: full header with bad magic, then an ignored trailing word
		add_word(32'h0000_0000);
		add_word(32'd1);
		add_word(32'd2);
		add_word(32'd3);
		add_word(32'hFFFF_FFFF);
		add_word(SPV_MAGIC);
		send_module();

		// Directed: capability, full entry point, short entry point, OpFunction,
		// then a word after the end
		add_word(SPV_MAGIC);
		add_word(32'h0001_0000);
		add_word(32'h0000_0000);
		add_word(32'hFFFF_FFFF);
		add_word(32'h0000_0000);
		add_word({16'd2, OP_CAPABILITY});
		add_word(32'hFFFF_FFFF);
		add_word({16'd5, OP_ENTRY_POINT});
		add_word(32'd5);
		add_word(32'd1);
		add_word(32'h6463_6261);       // four name bytes, no NUL
		add_word(32'h0000_6665);       // two bytes, then NUL
		add_word({16'd3, OP_ENTRY_POINT});
		add_word(32'hFFFF_FFFF);
		add_word(32'h1234_5678);
		add_word({16'd1, OP_FUNCTION});
		add_word(32'hFFFF_FFFF);
		send_module();

		while (words_sent < WORD_TARGET) begin
			build_random_module();
			send_module();
		end
		words_ch.valid <= 1'b0;

		// pending is assigned nonblocking at the clock edge, so look at it only after an edge has passed
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);

		$display("run covered %0d modules, %0d words, %0d records compared",
			modules_sent, words_sent, recs_checked);
		$display("header, magic, capability, entry point, name, zero-length and overrun cases");
		if (errors == 0)
			$display("spirv_header_scanner_unit: match");
		else
			$display("spirv_header_scanner_unit: mismatch");
		$finish;
	end

endmodule
